@@ src/fqs_pkg.sv @@
`timescale 1ns / 1ps

package fqs_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int WORD_W      = 32;
    localparam int CMD_W       = 2;
    localparam int STAT_W      = 2;
    localparam int POS_W       = 7;
    localparam int LEN_W       = 7;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    typedef struct packed {
        logic accept;
        logic deq_load;
        logic scan_read;
        logic scan_cmp;
        logic fin_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic empty;
        logic match;
        logic pend_valid;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

@@ src/fqs_ram.sv @@
`timescale 1ns / 1ps

module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/fqs_ctrl.sv @@
`timescale 1ns / 1ps

module fqs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  fqs_pkg::t_cmd     i_cmd,
    output logic              o_ready,
    input  fqs_pkg::t_dp_stat i_stat,
    output fqs_pkg::t_ctl_cmd o_ctl
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEQ  = 5'b00010,
        S_RD   = 5'b00100,
        S_CMP  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE) && i_stat.out_free;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.accept = i_valid && o_ready;
                if (o_ctl.accept && !i_stat.empty) begin
                    if (i_cmd == fqs_pkg::CMD_DEQ) begin
                        n_state = S_DEQ;
                    end else if (i_cmd == fqs_pkg::CMD_SEARCH) begin
                        n_state = S_RD;
                    end
                end
            end
            S_DEQ: begin
                o_ctl.deq_load = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                o_ctl.scan_read = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_ctl.scan_cmp = !(i_stat.match && i_stat.pend_valid) || i_stat.out_free;
                if (o_ctl.scan_cmp) begin
                    n_state = i_stat.scan_last ? S_FIN : S_RD;
                end
            end
            S_FIN: begin
                o_ctl.fin_load = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/fqs_dpath.sv @@
`timescale 1ns / 1ps

module fqs_dpath #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fqs_pkg::t_cmd               i_cmd,
    input  logic [fqs_pkg::WORD_W-1:0]  i_value,
    input  fqs_pkg::t_ctl_cmd           i_ctl,
    output fqs_pkg::t_dp_stat           o_stat,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output fqs_pkg::t_status            o_out_status,
    output logic [fqs_pkg::WORD_W-1:0]  o_out_word,
    output logic [fqs_pkg::POS_W-1:0]   o_out_pos,
    output logic [fqs_pkg::LEN_W-1:0]   o_out_len,
    output logic                        o_out_empty,
    output logic                        o_out_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0]               r_head, n_head;
    logic [AW-1:0]               r_tail, n_tail;
    logic [CW-1:0]               r_count, n_count;
    logic [AW-1:0]               r_scan_addr, n_scan_addr;
    logic [CW-1:0]               r_scan_i, n_scan_i;
    logic [fqs_pkg::WORD_W-1:0]  r_key;
    logic                        r_pend_v, n_pend_v;
    logic [fqs_pkg::POS_W-1:0]   r_pend_pos, n_pend_pos;

    logic                        r_out_valid;
    fqs_pkg::t_status            r_out_status;
    logic [fqs_pkg::WORD_W-1:0]  r_out_word;
    logic [fqs_pkg::POS_W-1:0]   r_out_pos;
    logic [fqs_pkg::LEN_W-1:0]   r_out_len;
    logic                        r_out_last;

    logic                        emit;
    fqs_pkg::t_status            e_status;
    logic [fqs_pkg::WORD_W-1:0]  e_word;
    logic [fqs_pkg::POS_W-1:0]   e_pos;
    logic                        e_last;

    logic                        we, re;
    logic [AW-1:0]               raddr;
    logic [fqs_pkg::WORD_W-1:0]  rdata;
    logic                        full, empty, out_free;
    logic [CW-1:0]               scan_i_inc;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    fqs_ram #(
        .WIDTH (fqs_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_tail),
        .i_wdata (i_value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign out_free   = !r_out_valid || i_out_ready;
    assign scan_i_inc = r_scan_i + 1'b1;

    assign o_stat.empty      = empty;
    assign o_stat.match      = (rdata == r_key);
    assign o_stat.pend_valid = r_pend_v;
    assign o_stat.scan_last  = (scan_i_inc == r_count);
    assign o_stat.out_free   = out_free;

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_scan_addr = r_scan_addr;
        n_scan_i    = r_scan_i;
        n_pend_v    = r_pend_v;
        n_pend_pos  = r_pend_pos;
        we          = 1'b0;
        re          = 1'b0;
        raddr       = r_scan_addr;
        emit        = 1'b0;
        e_status    = fqs_pkg::ST_OK;
        e_word      = '0;
        e_pos       = '0;
        e_last      = 1'b1;

        if (i_ctl.accept) begin
            n_scan_addr = r_head;
            n_scan_i    = '0;
            n_pend_v    = 1'b0;
            unique case (i_cmd)
                fqs_pkg::CMD_ENQ: begin
                    emit = 1'b1;
                    if (full) begin
                        e_status = fqs_pkg::ST_FULL;
                    end else begin
                        we      = 1'b1;
                        n_tail  = next_slot(r_tail);
                        n_count = r_count + 1'b1;
                    end
                end
                fqs_pkg::CMD_DEQ: begin
                    if (empty) begin
                        emit     = 1'b1;
                        e_status = fqs_pkg::ST_EMPTY;
                    end else begin
                        re    = 1'b1;
                        raddr = r_head;
                    end
                end
                fqs_pkg::CMD_SEARCH: begin
                    if (empty) begin
                        emit     = 1'b1;
                        e_status = fqs_pkg::ST_NOMATCH;
                    end
                end
                fqs_pkg::CMD_QUERY: begin
                    emit = 1'b1;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end

        if (i_ctl.deq_load) begin
            emit    = 1'b1;
            e_word  = rdata;
            n_head  = next_slot(r_head);
            n_count = r_count - 1'b1;
        end

        if (i_ctl.scan_read) begin
            re = 1'b1;
        end

        if (i_ctl.scan_cmp) begin
            if (o_stat.match) begin
                if (r_pend_v) begin
                    emit   = 1'b1;
                    e_word = r_key;
                    e_pos  = r_pend_pos;
                    e_last = 1'b0;
                end
                n_pend_v   = 1'b1;
                n_pend_pos = fqs_pkg::POS_W'(scan_i_inc);
            end
            n_scan_i    = scan_i_inc;
            n_scan_addr = next_slot(r_scan_addr);
        end

        if (i_ctl.fin_load) begin
            emit = 1'b1;
            if (r_pend_v) begin
                e_word = r_key;
                e_pos  = r_pend_pos;
            end else begin
                e_status = fqs_pkg::ST_NOMATCH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_addr <= n_scan_addr;
        r_scan_i    <= n_scan_i;
        r_pend_pos  <= n_pend_pos;
        if (i_ctl.accept) begin
            r_key <= i_value;
        end
        if (emit) begin
            r_out_status <= e_status;
            r_out_word   <= e_word;
            r_out_pos    <= e_pos;
            r_out_len    <= fqs_pkg::LEN_W'(n_count);
            r_out_last   <= e_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_word   = r_out_word;
    assign o_out_pos    = r_out_pos;
    assign o_out_len    = r_out_len;
    assign o_out_empty  = (r_out_len == '0);
    assign o_out_last   = r_out_last;

endmodule

@@ src/fifo_queue_with_search_unit.sv @@
`timescale 1ns / 1ps
// bounded fifo of signed 32-bit words with enqueue, dequeue, search and query
// input channel s_axis: tuser carries the command, tdata the word or search key
// output channel m_axis: tuser carries the status, tlast marks the final result
// of a command, tdata carries word_out, position, length and is_empty
// enqueue, query and every error result but a search miss on a non-empty queue
// are loaded into the output register straight from the command transaction; a
// dequeue first passes through the registered read of the entry memory
// a search reads the stored entries one at a time through the single read port
// of the memory, with a read state and a compare state per entry, then a final
// state for the final result; one result per match, with the last one marked
// one command is worked on at a time; the next command is taken once the
// controller is idle and the output register is empty or being drained
// if the receiver stalls, the output register holds its result and a search
// pauses until the pending match can be handed over
// reset empties the queue; the entry memory keeps its contents but is only read
// at occupied slots
module fifo_queue_with_search_unit #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [fqs_pkg::WORD_W-1:0]      s_axis_tdata,   // value[31:0]
    input  logic [fqs_pkg::CMD_W-1:0]       s_axis_tuser,   // cmd[1:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // word_out[31:0], position[38:32], length[45:39], is_empty[46], zero[47]
    output logic [fqs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [fqs_pkg::STAT_W-1:0]      m_axis_tuser,   // status[1:0]
    output logic                            m_axis_tlast
);

    fqs_pkg::t_ctl_cmd          ctl;
    fqs_pkg::t_dp_stat          stat;
    fqs_pkg::t_status           out_status;
    logic [fqs_pkg::WORD_W-1:0] out_word;
    logic [fqs_pkg::POS_W-1:0]  out_pos;
    logic [fqs_pkg::LEN_W-1:0]  out_len;
    logic                       out_empty;
    fqs_pkg::t_cmd              in_cmd;

    assign in_cmd = fqs_pkg::t_cmd'(s_axis_tuser);

    fqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_cmd   (in_cmd),
        .o_ready (s_axis_tready),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    fqs_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (in_cmd),
        .i_value      (s_axis_tdata),
        .i_ctl        (ctl),
        .o_stat       (stat),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_status (out_status),
        .o_out_word   (out_word),
        .o_out_pos    (out_pos),
        .o_out_len    (out_len),
        .o_out_empty  (out_empty),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_empty, out_len, out_pos, out_word};
    assign m_axis_tuser = out_status;

endmodule

@@ src/fqs_checker.sv @@
`timescale 1ns / 1ps

module fqs_checker #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [fqs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [fqs_pkg::STAT_W-1:0]      m_axis_tuser,
    input logic                            m_axis_tlast
);

    logic [fqs_pkg::LEN_W-1:0] len;
    logic [fqs_pkg::POS_W-1:0] pos;
    logic                      is_err;

    assign len    = m_axis_tdata[45:39];
    assign pos    = m_axis_tdata[38:32];
    assign is_err = (m_axis_tuser == fqs_pkg::ST_EMPTY) || (m_axis_tuser == fqs_pkg::ST_FULL)
                    || (m_axis_tuser == fqs_pkg::ST_NOMATCH);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[46] == (len == '0)) && !m_axis_tdata[47])
        else $error("is_empty disagrees with length");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && is_err |-> m_axis_tlast && (pos == '0) && (m_axis_tdata[31:0] == '0))
        else $error("error result not a single clean transaction");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == fqs_pkg::ST_FULL) |-> len == fqs_pkg::LEN_W'(DEPTH))
        else $error("full reported below capacity");

    a_dq_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == fqs_pkg::ST_EMPTY) |-> len == '0)
        else $error("empty reported with entries");

endmodule

bind fifo_queue_with_search_unit fqs_checker #(
    .DEPTH (DEPTH)
) u_fqs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ test/fifo_queue_with_search_unit_tb.sv @@
`timescale 1ns / 1ps

module fifo_queue_with_search_unit_tb;
    import fqs_pkg::*;

    localparam int QDEPTH     = DEPTH_DEF;
    localparam int STALL_PCT  = 25;
    localparam int HOLD_LEN   = 64;
    localparam int DRAIN_WAIT = 2 * QDEPTH + 8;
    localparam int IDLE_LIMIT = 1000;
    localparam int RAND_ITEMS = 200;
    localparam int BLOCK_LEN  = 25;

    typedef struct packed {
        t_status           status;
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        logic              empty;
        logic              last;
    } fq_result_t;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } mix_mode_t;

    // queue model and the results it still owes
    class queue_scoreboard;
        logic [WORD_W-1:0] held[$];
        fq_result_t        owed[$];
        int                errors;
        int                n_cmd[4];
        int                n_results;
        int                n_match;
        int                n_full;
        int                n_empty;
        int                n_nomatch;
        int                max_fill;

        function void report(string field, logic [WORD_W-1:0] expv, logic [WORD_W-1:0] actv);
            $display("%0t: mismatch in %s, expected %h, actual %h", $time, field, expv, actv);
            errors++;
        endfunction

        function void note_command(t_cmd cmd, logic [WORD_W-1:0] value);
            fq_result_t r;
            int hits;
            r = '0;
            r.last = 1'b1;
            hits = 0;
            n_cmd[cmd]++;
            case (cmd)
                CMD_ENQ: begin
                    if (held.size() >= QDEPTH) begin
                        r.status = ST_FULL;
                        n_full++;
                    end else begin
                        held.push_back(value);
                    end
                end
                CMD_DEQ: begin
                    if (held.size() == 0) begin
                        r.status = ST_EMPTY;
                        n_empty++;
                    end else begin
                        r.word = held.pop_front();
                    end
                end
                default: ;
            endcase
            if (held.size() > max_fill) max_fill = held.size();
            r.len = LEN_W'(held.size());
            r.empty = (held.size() == 0);
            if (cmd == CMD_SEARCH) begin
                r.last = 1'b0;
                foreach (held[i]) begin
                    if (held[i] == value) begin
                        r.word = value;
                        r.pos = POS_W'(i + 1);
                        owed.push_back(r);
                        hits++;
                    end
                end
                if (hits == 0) begin
                    r.status = ST_NOMATCH;
                    r.last = 1'b1;
                    owed.push_back(r);
                    n_nomatch++;
                end else begin
                    owed[$].last = 1'b1;
                    n_match += hits;
                end
            end else begin
                owed.push_back(r);
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic [STAT_W-1:0] user,
                                   logic last);
            fq_result_t r;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata %h tuser %0d tlast %0b",
                         $time, data, user, last);
                errors++;
                return;
            end
            r = owed.pop_front();
            n_results++;
            if (user !== r.status) report("status", WORD_W'(r.status), WORD_W'(user));
            if (data[31:0] !== r.word) report("word_out", r.word, data[31:0]);
            if (data[38:32] !== r.pos) report("position", WORD_W'(r.pos), WORD_W'(data[38:32]));
            if (data[45:39] !== r.len) report("length", WORD_W'(r.len), WORD_W'(data[45:39]));
            if (data[46] !== r.empty) report("is_empty", WORD_W'(r.empty), WORD_W'(data[46]));
            if (last !== r.last) report("last", WORD_W'(r.last), WORD_W'(last));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [WORD_W-1:0]      s_axis_tdata = '0;
    logic [CMD_W-1:0]       s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    queue_scoreboard sb = new();
    bit calm_phase = 1'b0;
    bit rx_hold_req = 1'b0;
    int idle_cycles = 0;

    fifo_queue_with_search_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stalls, always ready in the calm phase, or a long hold-off when asked
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (calm_phase) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= STALL_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_command(t_cmd'(s_axis_tuser), s_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_cmd(input t_cmd cmd, input logic [WORD_W-1:0] value);
        int gap;
        gap = 0;
        if (!calm_phase && $urandom_range(0, 99) < STALL_PCT) gap = $urandom_range(1, 4);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= value;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic wait_drained();
        while (sb.owed.size() != 0) @(posedge i_clk);
    endtask

    // mostly a small pool so searches hit, with the extremes in it
    function automatic logic [WORD_W-1:0] pick_word();
        if ($urandom_range(0, 99) >= 60) return $urandom();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'h0000_002A;
        endcase
    endfunction

    function automatic t_cmd pick_cmd(mix_mode_t mode);
        int r;
        int enq_pct;
        int deq_pct;
        r = $urandom_range(0, 99);
        enq_pct = (mode == MODE_FILL) ? 55 : (mode == MODE_DRAIN) ? 15 : 30;
        deq_pct = (mode == MODE_FILL) ? 15 : (mode == MODE_DRAIN) ? 55 : 30;
        if (r < enq_pct) return CMD_ENQ;
        if (r < enq_pct + deq_pct) return CMD_DEQ;
        if (r < 90) return CMD_SEARCH;
        return CMD_QUERY;
    endfunction

    initial begin
        mix_mode_t block_mode[8];
        t_cmd cmd;
        block_mode = '{MODE_FILL, MODE_FILL, MODE_DRAIN, MODE_MIXED,
                       MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_MIXED};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-queue errors, extremes, full queue, match at the tail
        send_cmd(CMD_DEQ, 32'h0);
        send_cmd(CMD_SEARCH, 32'h0);
        send_cmd(CMD_QUERY, 32'hFFFF_FFFF);
        send_cmd(CMD_ENQ, 32'h8000_0000);
        send_cmd(CMD_ENQ, 32'h7FFF_FFFF);
        send_cmd(CMD_ENQ, 32'h0000_0000);
        send_cmd(CMD_ENQ, 32'hFFFF_FFFF);
        repeat (QDEPTH - 5) send_cmd(CMD_ENQ, 32'h1234_5678);
        send_cmd(CMD_ENQ, 32'h8000_0000);
        send_cmd(CMD_ENQ, 32'h5555_5555);
        send_cmd(CMD_SEARCH, 32'h8000_0000);
        send_cmd(CMD_SEARCH, 32'h1234_5678);
        send_cmd(CMD_SEARCH, 32'h0000_0001);
        send_cmd(CMD_QUERY, 32'h0);
        send_cmd(CMD_DEQ, 32'h0);

        for (int b = 0; b < RAND_ITEMS / BLOCK_LEN; b++) begin
            calm_phase = (b == 1);
            for (int k = 0; k < BLOCK_LEN; k++) begin
                cmd = pick_cmd(block_mode[b]);
                send_cmd(cmd, (cmd == CMD_DEQ || cmd == CMD_QUERY) ? $urandom() : pick_word());
                // long receiver hold-off while commands keep coming
                if (b == 3 && k == 0) rx_hold_req = 1'b1;
            end
            if (b == 4) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
        end
        calm_phase = 1'b0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("commands: %0d enqueue, %0d dequeue, %0d search, %0d query; %0d results checked",
                 sb.n_cmd[CMD_ENQ], sb.n_cmd[CMD_DEQ], sb.n_cmd[CMD_SEARCH],
                 sb.n_cmd[CMD_QUERY], sb.n_results);
        $display("matches %0d, no-match %0d, full %0d, empty %0d, peak fill %0d, errors %0d",
                 sb.n_match, sb.n_nomatch, sb.n_full, sb.n_empty, sb.max_fill, sb.errors);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/fqs_pkg.sv
src/fqs_ram.sv
src/fqs_ctrl.sv
src/fqs_dpath.sv
src/fifo_queue_with_search_unit.sv
src/fqs_checker.sv
test/fifo_queue_with_search_unit_tb.sv
